/* rtl/extended_gcd_mod_inverse_top_defines.svh */
// assertion macros shared by the rtl files
`ifndef EXTENDED_GCD_MOD_INVERSE_TOP_DEFINES_SVH
`define EXTENDED_GCD_MOD_INVERSE_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define EGCD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define EGCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/egcd_pkg.sv */
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int OPW   = 32;
  localparam int CNT_W = $clog2(OPW);

  localparam logic [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};
  localparam logic [OPW-1:0] VAL_ZERO = '0;
  localparam logic [OPW-1:0] VAL_ONE  = {{(OPW-1){1'b0}}, 1'b1};
  localparam logic [OPW-2:0] GCD_ONE  = {{(OPW-2){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_WAIT,
    S_MUL_S,
    S_UPD_S,
    S_MUL_T,
    S_UPD_T,
    S_SIGN,
    S_INV_START,
    S_INV_WAIT,
    S_FINISH
  } egcd_state_t;

  // request toward the shared divider
  typedef struct packed {
    logic           start;
    logic [OPW-1:0] dividend;
    logic [OPW-1:0] divisor;
  } egcd_div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic           busy;
    logic           done;
    logic [OPW-1:0] quot;
    logic [OPW-1:0] rem;
  } egcd_div_rsp_t;

endpackage

/* rtl/extended_gcd_mod_inverse_top.sv */
`timescale 1ns / 1ps
`include "extended_gcd_mod_inverse_top_defines.svh"

// each euclid step runs check, divider wait, the s multiply and update, then the t multiply
// and update; sign, inverse and finish follow, and a zero second operand goes from check to sign
// throughput: one item at a time, paced by the bit-serial divider that the loop and inverse share
// next item is taken as soon as the previous result sits in the output register;
// a full, stalled output register holds the sequencer in finish
// reset: synchronous active-low rst_n clears the sequencer and the output valid flag

module extended_gcd_mod_inverse_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [egcd_pkg::OPW-1:0]     in_first_operand,
  input  logic signed [egcd_pkg::OPW-1:0]     in_second_operand,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [egcd_pkg::OPW-2:0]     out_gcd_value,
  output logic signed [egcd_pkg::OPW-1:0]     out_coef_x,
  output logic signed [egcd_pkg::OPW-1:0]     out_coef_y,
  output logic        [egcd_pkg::OPW-2:0]     out_inverse_value,
  output logic                                out_inverse_exists
);

  egcd_pkg::egcd_state_t   state_r, state_nxt;
  egcd_pkg::egcd_div_req_t div_req;
  egcd_pkg::egcd_div_rsp_t div_rsp;

  // working registers of the euclid loop
  logic [egcd_pkg::OPW-1:0] b0_r, b0_nxt;       // modulus kept for the inverse
  logic [egcd_pkg::OPW-1:0] ca_r, ca_nxt;
  logic [egcd_pkg::OPW-1:0] cb_r, cb_nxt;
  logic [egcd_pkg::OPW-1:0] os_r, os_nxt;       // bezout pair for a
  logic [egcd_pkg::OPW-1:0] s_r, s_nxt;
  logic [egcd_pkg::OPW-1:0] ot_r, ot_nxt;       // bezout pair for b
  logic [egcd_pkg::OPW-1:0] t_r, t_nxt;
  logic [egcd_pkg::OPW-1:0] q_r, q_nxt;
  logic [egcd_pkg::OPW-1:0] prod_r, prod_nxt;
  logic [egcd_pkg::OPW-2:0] g_r, g_nxt;
  logic [egcd_pkg::OPW-1:0] x_r, x_nxt;
  logic [egcd_pkg::OPW-1:0] y_r, y_nxt;
  logic [egcd_pkg::OPW-2:0] inv_r, inv_nxt;
  logic                     ok_r, ok_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [egcd_pkg::OPW-2:0] out_g_r, out_g_nxt;
  logic [egcd_pkg::OPW-1:0] out_x_r, out_x_nxt;
  logic [egcd_pkg::OPW-1:0] out_y_r, out_y_nxt;
  logic [egcd_pkg::OPW-2:0] out_inv_r, out_inv_nxt;
  logic                     out_ok_r, out_ok_nxt;

  logic                     in_xfer;
  logic                     out_xfer;
  logic [egcd_pkg::OPW-1:0] a_sat, b_sat;
  logic [egcd_pkg::OPW-1:0] mul_op;
  logic [2*egcd_pkg::OPW-1:0] mul_full;
  logic [egcd_pkg::OPW-1:0] ca_abs;
  logic [egcd_pkg::OPW-1:0] inv_fix;
  logic                     div_waiting;
  logic                     out_inv_ok;

  assign in_stall = (state_r != egcd_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // most negative operand is saturated one step toward zero
  assign a_sat = (in_first_operand == egcd_pkg::MOST_NEG) ?
                 (in_first_operand + egcd_pkg::VAL_ONE) : in_first_operand;
  assign b_sat = (in_second_operand == egcd_pkg::MOST_NEG) ?
                 (in_second_operand + egcd_pkg::VAL_ONE) : in_second_operand;

  // single multiplier, shared by the s and t updates; only the low half is kept
  assign mul_op   = (state_r == egcd_pkg::S_MUL_T) ? t_r : s_r;
  assign mul_full = q_r * mul_op;

  assign ca_abs  = ca_r[egcd_pkg::OPW-1] ? (-ca_r) : ca_r;
  // truncated remainder of x by a positive modulus, moved into [0, b)
  assign inv_fix = div_rsp.rem[egcd_pkg::OPW-1] ? (div_rsp.rem + b0_r) : div_rsp.rem;

  // shared divider: euclid quotient in the loop, x mod b at the end
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = ca_r;
    div_req.divisor  = cb_r;
    case (state_r)
      egcd_pkg::S_CHECK: begin
        div_req.start = (cb_r != egcd_pkg::VAL_ZERO);
      end
      egcd_pkg::S_INV_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = x_r;
        div_req.divisor  = b0_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  egcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    b0_nxt        = b0_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    os_nxt        = os_r;
    s_nxt         = s_r;
    ot_nxt        = ot_r;
    t_nxt         = t_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    g_nxt         = g_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    inv_nxt       = inv_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_g_nxt     = out_g_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_inv_nxt   = out_inv_r;
    out_ok_nxt    = out_ok_r;
    case (state_r)
      egcd_pkg::S_IDLE: begin
        if (in_xfer) begin
          b0_nxt    = b_sat;
          ca_nxt    = a_sat;
          cb_nxt    = b_sat;
          os_nxt    = egcd_pkg::VAL_ONE;
          s_nxt     = egcd_pkg::VAL_ZERO;
          ot_nxt    = egcd_pkg::VAL_ZERO;
          t_nxt     = egcd_pkg::VAL_ONE;
          state_nxt = egcd_pkg::S_CHECK;
        end
      end
      egcd_pkg::S_CHECK: begin
        if (cb_r == egcd_pkg::VAL_ZERO) begin
          state_nxt = egcd_pkg::S_SIGN;
        end else begin
          state_nxt = egcd_pkg::S_DIV_WAIT;
        end
      end
      egcd_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quot;
          ca_nxt    = cb_r;
          cb_nxt    = div_rsp.rem;
          state_nxt = egcd_pkg::S_MUL_S;
        end
      end
      egcd_pkg::S_MUL_S: begin
        prod_nxt  = mul_full[egcd_pkg::OPW-1:0];
        state_nxt = egcd_pkg::S_UPD_S;
      end
      egcd_pkg::S_UPD_S: begin
        os_nxt    = s_r;
        s_nxt     = os_r - prod_r;
        state_nxt = egcd_pkg::S_MUL_T;
      end
      egcd_pkg::S_MUL_T: begin
        prod_nxt  = mul_full[egcd_pkg::OPW-1:0];
        state_nxt = egcd_pkg::S_UPD_T;
      end
      egcd_pkg::S_UPD_T: begin
        ot_nxt    = t_r;
        t_nxt     = ot_r - prod_r;
        state_nxt = egcd_pkg::S_CHECK;
      end
      egcd_pkg::S_SIGN: begin
        // negative final remainder flips gcd and both coefficients
        g_nxt   = ca_abs[egcd_pkg::OPW-2:0];
        x_nxt   = ca_r[egcd_pkg::OPW-1] ? (-os_r) : os_r;
        y_nxt   = ca_r[egcd_pkg::OPW-1] ? (-ot_r) : ot_r;
        inv_nxt = '0;
        ok_nxt  = 1'b0;
        if ((ca_abs[egcd_pkg::OPW-2:0] == egcd_pkg::GCD_ONE) && !b0_r[egcd_pkg::OPW-1] &&
            (b0_r != egcd_pkg::VAL_ZERO)) begin
          state_nxt = egcd_pkg::S_INV_START;
        end else begin
          state_nxt = egcd_pkg::S_FINISH;
        end
      end
      egcd_pkg::S_INV_START: begin
        state_nxt = egcd_pkg::S_INV_WAIT;
      end
      egcd_pkg::S_INV_WAIT: begin
        if (div_rsp.done) begin
          inv_nxt   = inv_fix[egcd_pkg::OPW-2:0];
          ok_nxt    = 1'b1;
          state_nxt = egcd_pkg::S_FINISH;
        end
      end
      egcd_pkg::S_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_g_nxt     = g_r;
          out_x_nxt     = x_r;
          out_y_nxt     = y_r;
          out_inv_nxt   = inv_r;
          out_ok_nxt    = ok_r;
          state_nxt     = egcd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = egcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r      <= b0_nxt;
    ca_r      <= ca_nxt;
    cb_r      <= cb_nxt;
    os_r      <= os_nxt;
    s_r       <= s_nxt;
    ot_r      <= ot_nxt;
    t_r       <= t_nxt;
    q_r       <= q_nxt;
    prod_r    <= prod_nxt;
    g_r       <= g_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    inv_r     <= inv_nxt;
    ok_r      <= ok_nxt;
    out_g_r   <= out_g_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_inv_r <= out_inv_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_gcd_value      = out_g_r;
  assign out_coef_x         = out_x_r;
  assign out_coef_y         = out_y_r;
  assign out_inverse_value  = out_inv_r;
  assign out_inverse_exists = out_ok_r;

  // helper terms for the checks below
  assign div_waiting = (state_r == egcd_pkg::S_DIV_WAIT) || (state_r == egcd_pkg::S_INV_WAIT);
  assign out_inv_ok  = !out_valid_r || !out_ok_r || (out_g_r == egcd_pkg::GCD_ONE);

  `EGCD_ASSERT(a_top_done_expected, !div_rsp.done || div_waiting, "divider result unexpected")
  `EGCD_ASSERT(a_top_inv_gcd, out_inv_ok, "inverse flagged with gcd not one")
  `EGCD_ASSERT_NEXT(a_top_no_overwrite, out_valid_r && out_stall, out_valid_r, "result dropped")

endmodule

/* rtl/egcd_div.sv */
`timescale 1ns / 1ps
`include "extended_gcd_mod_inverse_top_defines.svh"

// signed truncating divider, one quotient bit per cycle (restoring)
module egcd_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  egcd_pkg::egcd_div_req_t req,
  output egcd_pkg::egcd_div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [egcd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [egcd_pkg::OPW-1:0]      rem_r, rem_nxt;
  logic [egcd_pkg::OPW-1:0]      quo_r, quo_nxt;
  logic [egcd_pkg::OPW-1:0]      dvs_r, dvs_nxt;
  logic                          qneg_r, qneg_nxt;
  logic                          rneg_r, rneg_nxt;
  logic [egcd_pkg::OPW:0]        trial;
  logic [egcd_pkg::OPW-1:0]      dnd_mag;
  logic [egcd_pkg::OPW-1:0]      dvs_mag;

  assign dnd_mag = req.dividend[egcd_pkg::OPW-1] ? (-req.dividend) : req.dividend;
  assign dvs_mag = req.divisor[egcd_pkg::OPW-1]  ? (-req.divisor)  : req.divisor;
  assign trial   = {rem_r, quo_r[egcd_pkg::OPW-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = egcd_pkg::CNT_LAST;
      rem_nxt  = '0;
      quo_nxt  = dnd_mag;
      dvs_nxt  = dvs_mag;
      qneg_nxt = req.dividend[egcd_pkg::OPW-1] ^ req.divisor[egcd_pkg::OPW-1];
      rneg_nxt = req.dividend[egcd_pkg::OPW-1];
    end else if (busy_r) begin
      if (!trial[egcd_pkg::OPW]) begin
        rem_nxt = trial[egcd_pkg::OPW-1:0];
        quo_nxt = {quo_r[egcd_pkg::OPW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[egcd_pkg::OPW-2:0], quo_r[egcd_pkg::OPW-1]};
        quo_nxt = {quo_r[egcd_pkg::OPW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = qneg_r ? (-quo_r) : quo_r;
  assign rsp.rem  = rneg_r ? (-rem_r) : rem_r;

  `EGCD_ASSERT(a_div_start_idle, !(req.start && busy_r), "divider started while busy")
  `EGCD_ASSERT(a_div_nonzero, !(req.start && (req.divisor == egcd_pkg::VAL_ZERO)), "divide by zero")
  `EGCD_ASSERT(a_div_rem_small, !done_r || (rem_r < dvs_r), "remainder not below divisor")
  `EGCD_ASSERT_NEXT(a_div_done_pulse, done_r, !done_r && !busy_r, "done longer than one cycle")

endmodule

/* tb/extended_gcd_mod_inverse_top_test.sv */
`timescale 1ns / 1ps

module extended_gcd_mod_inverse_top_test;

  localparam int OPW = egcd_pkg::OPW;
  localparam logic [OPW-1:0] MOST_NEG = egcd_pkg::MOST_NEG;
  localparam logic [OPW-1:0] VAL_ZERO = egcd_pkg::VAL_ZERO;
  localparam logic [OPW-1:0] VAL_ONE  = egcd_pkg::VAL_ONE;
  localparam logic [OPW-1:0] MAX_POS = ~MOST_NEG;
  localparam int NUM_ROWS = 24;
  localparam int RAND_PER_PHASE = 134;

  // one expected answer, in port widths
  typedef struct packed {
    logic [OPW-2:0] gcd;
    logic [OPW-1:0] x;
    logic [OPW-1:0] y;
    logic [OPW-2:0] inv;
    logic           exists;
  } egcd_result_t;

  // one directed operand pair, with the answer typed in where it is obvious
  typedef struct {
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    bit             known;
    egcd_result_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [OPW-1:0] in_first_operand = '0;
  logic [OPW-1:0] in_second_operand = '0;

  logic           in_stall;
  logic           out_valid;
  logic [OPW-2:0] out_gcd_value;
  logic [OPW-1:0] out_coef_x;
  logic [OPW-1:0] out_coef_y;
  logic [OPW-2:0] out_inverse_value;
  logic           out_inverse_exists;

  // answers owed by the block, oldest first
  egcd_result_t pending_results[$];

  int tx_idle_pct = 25;
  int rx_idle_pct = 70;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int inverse_count = 0;
  int deep_count = 0;

  // directed pairs: zero modulus, saturation of the most negative value,
  // negative and unit moduli, shared factors and the longest euclid chains
  stim_row_t dir_table [NUM_ROWS] = '{
    '{VAL_ZERO, VAL_ZERO, 1'b1, '{31'd0, VAL_ONE, VAL_ZERO, 31'd0, 1'b0}},
    '{32'd5, VAL_ZERO, 1'b1, '{31'd5, VAL_ONE, VAL_ZERO, 31'd0, 1'b0}},
    '{-32'sd7, VAL_ZERO, 1'b1, '{31'd7, '1, VAL_ZERO, 31'd0, 1'b0}},
    '{MOST_NEG, VAL_ZERO, 1'b1, '{'1, '1, VAL_ZERO, 31'd0, 1'b0}},
    '{MAX_POS, VAL_ZERO, 1'b1, '{'1, VAL_ONE, VAL_ZERO, 31'd0, 1'b0}},
    '{VAL_ZERO, 32'd5, 1'b0, '0},
    '{VAL_ZERO, -32'sd5, 1'b0, '0},
    '{32'd3, 32'd7, 1'b0, '0},
    '{32'd3, -32'sd7, 1'b0, '0},
    '{32'd3, VAL_ONE, 1'b0, '0},
    '{32'd4, 32'd6, 1'b0, '0},
    '{-32'sd3, 32'd7, 1'b0, '0},
    '{VAL_ONE, VAL_ONE, 1'b0, '0},
    '{'1, '1, 1'b0, '0},
    '{MAX_POS, MAX_POS - 1, 1'b0, '0},
    '{MOST_NEG, MOST_NEG, 1'b0, '0},
    '{MOST_NEG + 1, MAX_POS, 1'b0, '0},
    '{32'd1836311903, 32'd1134903170, 1'b0, '0},
    '{-32'sd1134903170, 32'd1836311903, 1'b0, '0},
    '{32'd17, 32'd3120, 1'b0, '0},
    '{MAX_POS, 32'd2, 1'b0, '0},
    '{32'd2, MAX_POS, 1'b0, '0},
    '{32'd12345, MOST_NEG, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
  };

  logic [OPW-1:0] corner_vals [6] = '{VAL_ZERO, VAL_ONE, '1, MOST_NEG, MAX_POS, MOST_NEG + 1};

  extended_gcd_mod_inverse_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_operand   (in_first_operand),
    .in_second_operand  (in_second_operand),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_gcd_value      (out_gcd_value),
    .out_coef_x         (out_coef_x),
    .out_coef_y         (out_coef_y),
    .out_inverse_value  (out_inverse_value),
    .out_inverse_exists (out_inverse_exists)
  );

  always #4 clk = ~clk;

  // gcd, bezout pair and inverse of a modulo b, computed in 64-bit arithmetic
  function automatic egcd_result_t euclid_result(input logic [OPW-1:0] a_raw,
                                                 input logic [OPW-1:0] b_raw);
    longint a;
    longint b;
    longint ca;
    longint cb;
    longint rem;
    longint quots[$];
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    int i;
    egcd_result_t res;
    // the most negative value is pulled in by one
    a = longint'($signed(a_raw == MOST_NEG ? a_raw + 1'b1 : a_raw));
    b = longint'($signed(b_raw == MOST_NEG ? b_raw + 1'b1 : b_raw));
    ca = a;
    cb = b;
    // truncating division all the way down, quotients kept for the way back
    while (cb != 0) begin
      quots = {quots, ca / cb};
      rem = ca % cb;
      ca = cb;
      cb = rem;
    end
    g = (ca >= 0) ? ca : -ca;
    x = (ca >= 0) ? 64'd1 : '1;
    y = '0;
    // back substitution, wrapping like plain 64-bit integers
    for (i = quots.size() - 1; i >= 0; i--) begin
      t = x - quots[i] * y;
      x = y;
      y = t;
    end
    res = '0;
    res.gcd = g[OPW-2:0];
    res.x = x[OPW-1:0];
    res.y = y[OPW-1:0];
    // inverse only for a unit gcd and a positive modulus
    if (g == 64'd1 && b > 0) begin
      rem = $signed(x) % b;
      rem = (rem + b) % b;
      res.inv = rem[OPW-2:0];
      res.exists = 1'b1;
    end
    return res;
  endfunction

  // present one pair, wait for the transfer and record what is owed
  task automatic send_operands(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                               input bit known, input egcd_result_t known_res);
    egcd_result_t owed;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_operand <= a;
    in_second_operand <= b;
    do @(posedge clk); while (in_stall);
    owed = known ? known_res : euclid_result(a, b);
    pending_results = {pending_results, owed};
    sent_count++;
  endtask

  // sender holds off until every owed result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure, random at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // result checker: every transfer out is matched against the oldest owed answer
  always @(posedge clk) begin
    egcd_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding: gcd %0d x %0d y %0d",
               out_gcd_value, $signed(out_coef_x), $signed(out_coef_y));
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        checked_count++;
        if (out_inverse_exists) inverse_count++;
        if (out_gcd_value !== exp_res.gcd) begin
          $error("gcd_value: expected %0d, got %0d", exp_res.gcd, out_gcd_value);
          error_count++;
        end
        if (out_coef_x !== exp_res.x) begin
          $error("coef_x: expected %0d, got %0d", $signed(exp_res.x), $signed(out_coef_x));
          error_count++;
        end
        if (out_coef_y !== exp_res.y) begin
          $error("coef_y: expected %0d, got %0d", $signed(exp_res.y), $signed(out_coef_y));
          error_count++;
        end
        if (out_inverse_value !== exp_res.inv) begin
          $error("inverse_value: expected %0d, got %0d", exp_res.inv, out_inverse_value);
          error_count++;
        end
        if (out_inverse_exists !== exp_res.exists) begin
          $error("inverse_exists: expected %0d, got %0d", exp_res.exists,
                 out_inverse_exists);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int n;
    int k;
    longint fa;
    longint fb;
    longint ft;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender idles a quarter of the time, receiver stalls often
    for (n = 0; n < NUM_ROWS; n++) begin
      send_operands(dir_table[n].a, dir_table[n].b, dir_table[n].known, dir_table[n].res);
    end
    drain_results();

    // random phases: light sender idling, then heavy, then none at all
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 25; rx_idle_pct = 70; end
        1: begin tx_idle_pct = 70; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // full-width operands
            a = $urandom;
            b = $urandom;
          end
          4, 5: begin
            // small values near zero
            a = $urandom_range(2000) - 1000;
            b = $urandom_range(2000) - 1000;
          end
          6: begin
            // typical inverse use: any value against a modest positive modulus
            a = $urandom;
            b = $urandom_range(100000, 1);
          end
          7: begin
            // consecutive fibonacci numbers give the longest euclid chains
            k = $urandom_range(46, 20);
            fa = 0;
            fb = 1;
            repeat (k - 1) begin
              ft = fa + fb;
              fa = fb;
              fb = ft;
            end
            a = fb[OPW-1:0];
            b = fa[OPW-1:0];
            if ($urandom_range(1)) a = -a;
            if ($urandom_range(1)) b = -b;
            deep_count++;
          end
          8: begin
            // corner values on either side
            a = $urandom_range(1) ? corner_vals[$urandom_range(5)] : $urandom;
            b = corner_vals[$urandom_range(5)];
            if ($urandom_range(1)) begin
              a = corner_vals[$urandom_range(5)];
              b = $urandom;
            end
          end
          default: begin
            // shared factor, so no inverse unless b is 1
            b = $urandom_range(46340, 1);
            a = b * $urandom_range(46340, 1);
            if ($urandom_range(1)) a = -a;
            if ($urandom_range(1)) b = -b;
          end
        endcase
        send_operands(a, b, 1'b0, '0);
      end
      // sender pauses until everything owed has come back
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (100) @(posedge clk);

    $display("ran %0d operand pairs (%0d long fibonacci chains) across three idle patterns",
             sent_count, deep_count);
    $display("checked %0d results, %0d with an inverse, %0d still outstanding",
             checked_count, inverse_count, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
